// File: rtl/core/mncv_pkg.sv
`timescale 1ns / 1ps

package mncv_pkg;

    localparam int ITEM_W = 7;

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_CTRL     = 2'd2;

    localparam logic [1:0] MODE_VELOCITY = 2'd0;
    localparam logic [1:0] MODE_UNISON   = 2'd1;
    localparam logic [1:0] MODE_MODWHEEL = 2'd2;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_ZERO_NOTE = 2'd1;
    localparam logic [1:0] REG_CV_ENABLE = 2'd2;

    localparam logic [6:0] CC_MODWHEEL = 7'd1;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX1,
        RD_TOP
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    cc_update;
        logic    idx_clear;
        logic    idx_inc;
        rd_sel_t rd_sel;
        logic    push_wr;
        logic    shift_wr;
        logic    depth_inc;
        logic    depth_dec;
        logic    take_top;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_note_on;
        logic is_note_off;
        logic is_cc;
        logic idx_lt_depth;
        logic idx1_lt_depth;
        logic match;
        logic depth_lt_max;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/mono_note_to_cv_last_priority.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_ready     kind, note_number, amount
// out       out_valid / out_ready   pitch_offset, aux_level, aux_is_pitch, cv_written,
//                                   gate_level, held_count
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A note transaction scans the stack memory entry by entry (read, then compare), closes the
// gap left by a removed note (read, then write, per entry) and reads the top entry; a control
// change ends after decode with no output. Reset is asynchronous and needs no clearing pass;
// only stack entries below the fill count are used. A finished result waits in the output
// register while the next input transaction is accepted and processed up to its output step.
module mono_note_to_cv_last_priority #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             kind,
    input  logic [6:0]                             note_number,
    input  logic [6:0]                             amount,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [7:0]                      pitch_offset,
    output logic [6:0]                             aux_level,
    output logic                                   aux_is_pitch,
    output logic                                   cv_written,
    output logic                                   gate_level,
    output logic [$clog2(STACK_DEPTH + 1)-1:0]     held_count,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [6:0]                             cfg_data
);
    import mncv_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mncv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mncv_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .note_number  (note_number),
        .amount       (amount),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .pitch_offset (pitch_offset),
        .aux_level    (aux_level),
        .aux_is_pitch (aux_is_pitch),
        .cv_written   (cv_written),
        .gate_level   (gate_level),
        .held_count   (held_count)
    );

endmodule

// File: rtl/core/mncv_ctrl.sv
`timescale 1ns / 1ps

module mncv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mncv_pkg::dp_status_t status,
    output mncv_pkg::ctrl_cmd_t  cmd
);
    import mncv_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_SH_RD  = 4'd4;
    localparam logic [3:0] S_SH_WR  = 4'd5;
    localparam logic [3:0] S_TOP_RD = 4'd6;
    localparam logic [3:0] S_TOP    = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_note_on || status.is_note_off)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_RD;
                end
                else
                begin
                    cmd.cc_update = status.is_cc;
                    state_next    = S_IDLE;
                end
            end
            S_RD:
            begin
                if (status.idx_lt_depth)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    if (status.is_note_on && status.depth_lt_max)
                    begin
                        cmd.push_wr   = 1'b1;
                        cmd.depth_inc = 1'b1;
                    end
                    state_next = S_TOP_RD;
                end
            end
            S_CMP:
            begin
                if (status.match)
                begin
                    state_next = status.is_note_on ? S_TOP_RD : S_SH_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_SH_RD:
            begin
                cmd.rd_sel = RD_IDX1;
                if (status.idx1_lt_depth)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    cmd.depth_dec = 1'b1;
                    state_next    = S_TOP_RD;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SH_RD;
            end
            S_TOP_RD:
            begin
                cmd.rd_sel = RD_TOP;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                cmd.take_top = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/mncv_dp.sv
`timescale 1ns / 1ps

module mncv_dp #(
    parameter int STACK_DEPTH = 16,
    parameter int CW          = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mncv_pkg::ctrl_cmd_t  cmd,
    output mncv_pkg::dp_status_t status,
    input  logic [1:0]           kind,
    input  logic [6:0]           note_number,
    input  logic [6:0]           amount,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic signed [7:0]    pitch_offset,
    output logic [6:0]           aux_level,
    output logic                 aux_is_pitch,
    output logic                 cv_written,
    output logic                 gate_level,
    output logic [CW-1:0]        held_count
);
    import mncv_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int EW = 2 * ITEM_W;

    logic [1:0]        kind_reg;
    logic [6:0]        num_reg;
    logic [6:0]        amt_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     depth_reg;
    logic [6:0]        last_note_reg;
    logic [6:0]        last_vel_reg;
    logic [6:0]        modwheel_reg;
    logic              gate_reg;
    logic [1:0]        mode_reg;
    logic [6:0]        zero_note_reg;
    logic              cv_en_reg;
    logic              out_valid_reg;
    logic [7:0]        pitch_reg;
    logic [6:0]        aux_reg;
    logic              unison_reg;
    logic              written_reg;
    logic              gate_out_reg;
    logic [CW-1:0]     count_reg;
    logic [EW-1:0]     rd_data_reg;
    logic [EW-1:0]     stack_mem [STACK_DEPTH];

    logic [CW:0]       idx1;
    logic [CW-1:0]     depth_m1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic              wr_en;
    logic              gate_new;
    logic [7:0]        pitch_new;
    logic [6:0]        aux_new;

    assign idx1     = {1'b0, idx_reg} + (CW + 1)'(1);
    assign depth_m1 = depth_reg - CW'(1);

    assign status.is_note_on    = (kind_reg == KIND_NOTE_ON) && (amt_reg != 7'd0);
    assign status.is_note_off   = ((kind_reg == KIND_NOTE_ON) && (amt_reg == 7'd0))
                                  || (kind_reg == KIND_NOTE_OFF);
    assign status.is_cc         = (kind_reg == KIND_CTRL);
    assign status.idx_lt_depth  = (idx_reg < depth_reg);
    assign status.idx1_lt_depth = (idx1 < {1'b0, depth_reg});
    assign status.match         = (rd_data_reg[EW-1:ITEM_W] == num_reg);
    assign status.depth_lt_max  = (depth_reg < CW'(STACK_DEPTH));
    assign status.out_free      = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  rd_addr = idx_reg[AW-1:0];
            RD_IDX1: rd_addr = idx1[AW-1:0];
            RD_TOP:  rd_addr = depth_m1[AW-1:0];
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    assign wr_en   = cmd.push_wr || cmd.shift_wr;
    assign wr_addr = cmd.push_wr ? depth_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data = cmd.push_wr ? {num_reg, amt_reg} : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind;
            num_reg  <= note_number;
            amt_reg  <= amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            depth_reg     <= '0;
            last_note_reg <= '0;
            last_vel_reg  <= '0;
            modwheel_reg  <= '0;
            gate_reg      <= 1'b0;
            mode_reg      <= MODE_VELOCITY;
            zero_note_reg <= '0;
            cv_en_reg     <= 1'b1;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx1[CW-1:0];
            end
            if (cmd.depth_inc)
            begin
                depth_reg <= depth_reg + CW'(1);
            end
            else if (cmd.depth_dec)
            begin
                depth_reg <= depth_m1;
            end
            if (cmd.take_top && cv_en_reg && (depth_reg != '0))
            begin
                last_note_reg <= rd_data_reg[EW-1:ITEM_W];
                last_vel_reg  <= rd_data_reg[ITEM_W-1:0];
            end
            if (cmd.cc_update && (num_reg == CC_MODWHEEL))
            begin
                modwheel_reg <= amt_reg;
            end
            if (cmd.load_out)
            begin
                gate_reg <= gate_new;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MODE:      mode_reg      <= cfg_data[1:0];
                    REG_ZERO_NOTE: zero_note_reg <= cfg_data;
                    REG_CV_ENABLE: cv_en_reg     <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    always_comb
    begin
        gate_new  = status.is_note_on ? 1'b1 : ((depth_reg == '0) ? 1'b0 : gate_reg);
        pitch_new = {1'b0, last_note_reg} - {1'b0, zero_note_reg};
        case (mode_reg)
            MODE_UNISON:   aux_new = 7'd0;
            MODE_MODWHEEL: aux_new = modwheel_reg;
            default:       aux_new = last_vel_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pitch_reg    <= cv_en_reg ? pitch_new : 8'd0;
            aux_reg      <= cv_en_reg ? aux_new : 7'd0;
            unison_reg   <= cv_en_reg && (mode_reg == MODE_UNISON);
            written_reg  <= cv_en_reg;
            gate_out_reg <= gate_new;
            count_reg    <= depth_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pitch_offset = pitch_reg;
    assign aux_level    = aux_reg;
    assign aux_is_pitch = unison_reg;
    assign cv_written   = written_reg;
    assign gate_level   = gate_out_reg;
    assign held_count   = count_reg;

endmodule

// File: rtl/core/mncv_chk.sv
`timescale 1ns / 1ps

module mncv_chk #(
    parameter int STACK_DEPTH = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [7:0]                  pitch_offset,
    input logic [6:0]                         aux_level,
    input logic                               aux_is_pitch,
    input logic                               cv_written,
    input logic                               gate_level,
    input logic [$clog2(STACK_DEPTH + 1)-1:0] held_count
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch_offset)
            && $stable(aux_level) && $stable(held_count) && $stable(gate_level))
        else $error("Stalled output transaction changed or was dropped.");

    a_gate_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gate_level == (held_count != '0)))
        else $error("Gate level disagrees with the number of held notes.");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_count <= CW'(STACK_DEPTH)))
        else $error("Held note count exceeds the stack depth.");

    a_cv_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cv_written |-> (pitch_offset == 8'sd0) && (aux_level == 7'd0)
            && !aux_is_pitch)
        else $error("Pitch or aux values present while CV updates are disabled.");

    a_unison_aux: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && aux_is_pitch |-> cv_written && (aux_level == 7'd0))
        else $error("Aux level is not zero in unison mode.");

endmodule

bind mono_note_to_cv_last_priority mncv_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_mncv_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pitch_offset (pitch_offset),
    .aux_level    (aux_level),
    .aux_is_pitch (aux_is_pitch),
    .cv_written   (cv_written),
    .gate_level   (gate_level),
    .held_count   (held_count)
);
